### rtl/stl_pkg.sv
// ============================================================================
// SQL token lexer package
// Shared widths, mode codes, token kinds and character classes.
// ============================================================================
`default_nettype none

package stl_pkg;

    localparam int STRING_CAPACITY_DEF = 256;
    localparam int COUNTER_BITS_DEF    = 16;
    localparam int OUT_BITS            = 16;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_IDENT   = 3'd1;
    localparam logic [2:0] M_NUMBER  = 3'd2;
    localparam logic [2:0] M_SIGN    = 3'd3;
    localparam logic [2:0] M_COMMENT = 3'd4;
    localparam logic [2:0] M_STRING  = 3'd5;
    localparam logic [2:0] M_QUOTE   = 3'd6;
    localparam logic [2:0] M_HALT    = 3'd7;

    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_INT    = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_SELECT = 5'd4;
    localparam logic [4:0] K_INSERT = 5'd5;
    localparam logic [4:0] K_VALUES = 5'd6;
    localparam logic [4:0] K_WHERE  = 5'd7;
    localparam logic [4:0] K_INTO   = 5'd8;
    localparam logic [4:0] K_NULL   = 5'd9;
    localparam logic [4:0] K_FROM   = 5'd10;
    localparam logic [4:0] K_LPAREN = 5'd11;
    localparam logic [4:0] K_RPAREN = 5'd12;
    localparam logic [4:0] K_COMMA  = 5'd13;
    localparam logic [4:0] K_SEMI   = 5'd14;
    localparam logic [4:0] K_STAR   = 5'd15;
    localparam logic [4:0] K_EQ     = 5'd16;
    localparam logic [4:0] K_PLUS   = 5'd17;
    localparam logic [4:0] K_MINUS  = 5'd18;
    localparam logic [4:0] K_ERROR  = 5'd19;
    localparam logic [4:0] K_CHAR   = 5'd20;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // One result as it leaves the lexer core.
    typedef struct packed {
        logic [4:0]          kind;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic [OUT_BITS-1:0] line;
        logic [OUT_BITS-1:0] column;
        logic [7:0]          char_value;
    } result_t;

    // A group of up to two results caused by one input item.
    typedef struct packed {
        logic    count2;
        result_t first;
        result_t second;
    } result_pair_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    endfunction

endpackage

`default_nettype wire

### rtl/stl_kw.sv
// ============================================================================
// Keyword classifier
// Maps a finished identifier to its keyword kind or to IDENT.
// ============================================================================
`default_nettype none

module stl_kw #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic [47:0]             chars,
    input  wire logic [COUNTER_BITS-1:0] length,
    output logic [4:0]                   kind
);
    import stl_pkg::*;

    always_comb
    begin
        kind = K_IDENT;
        if (length == COUNTER_BITS'(6))
        begin
            if (chars == {8'h74, 8'h63, 8'h65, 8'h6c, 8'h65, 8'h73}) kind = K_SELECT;
            if (chars == {8'h74, 8'h72, 8'h65, 8'h73, 8'h6e, 8'h69}) kind = K_INSERT;
            if (chars == {8'h73, 8'h65, 8'h75, 8'h6c, 8'h61, 8'h76}) kind = K_VALUES;
        end
        if (length == COUNTER_BITS'(5))
        begin
            if (chars == {8'h00, 8'h65, 8'h72, 8'h65, 8'h68, 8'h77}) kind = K_WHERE;
        end
        if (length == COUNTER_BITS'(4))
        begin
            if (chars == {16'h0, 8'h6f, 8'h74, 8'h6e, 8'h69}) kind = K_INTO;
            if (chars == {16'h0, 8'h6c, 8'h6c, 8'h75, 8'h6e}) kind = K_NULL;
            if (chars == {16'h0, 8'h6d, 8'h6f, 8'h72, 8'h66}) kind = K_FROM;
        end
    end

endmodule

`default_nettype wire

### rtl/stl_core.sv
// ============================================================================
// Lexer core
// Holds the lexer state and computes, for one registered item, the next state
// and up to two results.
// ============================================================================
`default_nettype none

module stl_core #(
    parameter int STRING_CAPACITY = 256,
    parameter int COUNTER_BITS    = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 cmd,
    input  wire logic [7:0]           byte_value,
    output stl_pkg::result_pair_t     results,
    output logic                      any_result
);
    import stl_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    // Decoded length limit (capacity minus one); compare in a wider word.
    localparam logic [CB:0] CAP_M1 = (CB+1)'(STRING_CAPACITY - 1);

    logic [2:0]    mode_reg, mode_next;
    logic [CB-1:0] pos_reg, pos_next, line_reg, line_next, col_reg, col_next;
    logic [CB-1:0] tpos_reg, tpos_next, tline_reg, tline_next, tcol_reg, tcol_next;
    logic [CB-1:0] tlen_reg, tlen_next;
    logic [47:0]   kw_reg, kw_next;
    logic          plus_reg, plus_next;

    logic [4:0]    ident_kind;

    stl_kw #(.COUNTER_BITS(CB)) u_kw (
        .chars  (kw_reg),
        .length (tlen_reg),
        .kind   (ident_kind)
    );

    function automatic logic [OUT_BITS-1:0] sat16(input logic [CB-1:0] v);
        logic [OUT_BITS-1:0] r;
        r = {OUT_BITS{1'b1}};
        if ({{32{1'b0}}, v} <= {{(32+CB-OUT_BITS){1'b0}}, {OUT_BITS{1'b1}}})
            r = OUT_BITS'(v);
        return r;
    endfunction

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == CMAX) ? v : v + CB'(1);
    endfunction

    function automatic result_t mk(input logic [4:0] k, input logic [CB-1:0] s,
                                   input logic [CB-1:0] len, input logic [CB-1:0] l,
                                   input logic [CB-1:0] c, input logic [7:0] ch);
        result_t r;
        r.kind = k;
        r.start = sat16(s);
        r.length = sat16(len);
        r.line = sat16(l);
        r.column = sat16(c);
        r.char_value = ch;
        return r;
    endfunction

    result_t r0, r1;
    logic [1:0] n;

    always_comb
    begin
        logic       fresh;
        logic       flush_valid;
        result_t    flush_r;
        logic       is_sep;
        logic [4:0] pk;
        logic       sbyte;
        logic [7:0] b;
        b = byte_value;
        mode_next = mode_reg;
        pos_next = pos_reg; line_next = line_reg; col_next = col_reg;
        tpos_next = tpos_reg; tline_next = tline_reg; tcol_next = tcol_reg;
        tlen_next = tlen_reg; kw_next = kw_reg; plus_next = plus_reg;
        r0 = '0; r1 = '0; n = 2'd0;
        fresh = 1'b0; flush_valid = 1'b0; flush_r = '0; sbyte = 1'b0;
        pk = plus_reg ? K_PLUS : K_MINUS;
        is_sep = (b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a);

        // Token pending in the held state, as the end item or a terminator ends it.
        case (mode_reg)
            M_IDENT:  begin flush_valid = 1'b1;
                flush_r = mk(ident_kind, tpos_reg, tlen_reg, tline_reg, tcol_reg, 8'h0); end
            M_NUMBER: begin flush_valid = 1'b1;
                flush_r = mk(K_INT, tpos_reg, tlen_reg, tline_reg, tcol_reg, 8'h0); end
            M_SIGN:   begin flush_valid = 1'b1;
                flush_r = mk(pk, tpos_reg, CB'(1), tline_reg, tcol_reg, 8'h0); end
            M_QUOTE:  begin flush_valid = 1'b1;
                flush_r = mk(K_STRING, tpos_reg, tlen_reg, tline_reg, tcol_reg, 8'h0); end
            M_STRING: begin flush_valid = 1'b1;
                flush_r = mk(K_ERROR, tpos_reg, tlen_reg, tline_reg, tcol_reg, 8'h0); end
            default:  flush_valid = 1'b0;
        endcase

        if (cmd == CMD_END)
        begin
            if (flush_valid)
            begin
                r0 = flush_r;
                r1 = mk(K_EOF, pos_reg, CB'(0), line_reg, col_reg, 8'h0);
                n = 2'd2;
            end
            else
            begin
                r0 = mk(K_EOF, pos_reg, CB'(0), line_reg, col_reg, 8'h0);
                n = 2'd1;
            end
            mode_next = M_IDLE;
            pos_next = '0; line_next = CB'(1); col_next = CB'(1);
            tpos_next = '0; tline_next = CB'(1); tcol_next = CB'(1);
            tlen_next = '0; kw_next = '0; plus_next = 1'b0;
        end
        else if (mode_reg != M_HALT)
        begin
            case (mode_reg)
                M_IDENT:
                    if (is_alpha(b) || is_digit(b))
                    begin
                        case (tlen_reg)
                            CB'(1): kw_next[15:8]  = to_lower(b);
                            CB'(2): kw_next[23:16] = to_lower(b);
                            CB'(3): kw_next[31:24] = to_lower(b);
                            CB'(4): kw_next[39:32] = to_lower(b);
                            CB'(5): kw_next[47:40] = to_lower(b);
                            default: kw_next = kw_reg;
                        endcase
                        tlen_next = sat_inc(tlen_reg);
                    end
                    else begin r0 = flush_r; n = 2'd1; fresh = 1'b1; end
                M_NUMBER:
                    if (is_digit(b)) tlen_next = sat_inc(tlen_reg);
                    else begin r0 = flush_r; n = 2'd1; fresh = 1'b1; end
                M_SIGN:
                    if (is_digit(b))
                    begin
                        mode_next = M_NUMBER; tlen_next = CB'(2);
                    end
                    else if (b == 8'h2d && !plus_reg) mode_next = M_COMMENT;
                    else begin r0 = flush_r; n = 2'd1; fresh = 1'b1; end
                M_COMMENT:
                    if (b == 8'h0a) mode_next = M_IDLE;
                M_STRING:
                    if (b == 8'h27) mode_next = M_QUOTE;
                    else sbyte = 1'b1;
                M_QUOTE:
                    if (b == 8'h27) sbyte = 1'b1;
                    else begin r0 = flush_r; n = 2'd1; fresh = 1'b1; end
                default:
                    fresh = 1'b1;
            endcase

            if (sbyte)
            begin
                if ({1'b0, tlen_reg} + (CB+1)'(1) > CAP_M1)
                begin
                    r0 = mk(K_ERROR, tpos_reg, tlen_reg, tline_reg, tcol_reg, 8'h0);
                    mode_next = M_HALT;
                end
                else
                begin
                    r0 = mk(K_CHAR, tpos_reg, CB'(1), tline_reg, tcol_reg, b);
                    tlen_next = sat_inc(tlen_reg);
                    mode_next = M_STRING;
                end
                n = 2'd1;
            end

            if (fresh)
            begin
                result_t fr;
                logic    emit_f;
                logic [4:0] k;
                fr = '0; emit_f = 1'b0; k = K_ERROR;
                tpos_next = pos_reg; tline_next = line_reg; tcol_next = col_reg;
                mode_next = M_IDLE;
                if (is_sep) mode_next = M_IDLE;
                else if (is_alpha(b))
                begin
                    mode_next = M_IDENT; tlen_next = CB'(1); kw_next = {40'h0, to_lower(b)};
                end
                else if (b == 8'h2b || b == 8'h2d)
                begin
                    mode_next = M_SIGN; plus_next = (b == 8'h2b); tlen_next = CB'(1);
                end
                else if (is_digit(b)) begin mode_next = M_NUMBER; tlen_next = CB'(1); end
                else if (b == 8'h27) begin mode_next = M_STRING; tlen_next = '0; end
                else
                begin
                    case (b)
                        8'h28:   k = K_LPAREN;
                        8'h29:   k = K_RPAREN;
                        8'h2c:   k = K_COMMA;
                        8'h3b:   k = K_SEMI;
                        8'h2a:   k = K_STAR;
                        8'h3d:   k = K_EQ;
                        default: begin k = K_ERROR; mode_next = M_HALT; end
                    endcase
                    emit_f = 1'b1;
                    fr = mk(k, pos_reg, CB'(1), line_reg, col_reg, 8'h0);
                end
                if (emit_f)
                begin
                    if (n == 2'd0) begin r0 = fr; n = 2'd1; end
                    else begin r1 = fr; n = 2'd2; end
                end
            end

            pos_next = sat_inc(pos_reg);
            if (b == 8'h0a) begin line_next = sat_inc(line_reg); col_next = CB'(1); end
            else col_next = sat_inc(col_reg);
        end
    end

    assign any_result     = (n != 2'd0);
    assign results.count2 = (n == 2'd2);
    assign results.first  = r0;
    assign results.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg <= '0; line_reg <= CB'(1); col_reg <= CB'(1);
            tpos_reg <= '0; tline_reg <= CB'(1); tcol_reg <= CB'(1);
            tlen_reg <= '0; kw_reg <= '0; plus_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next; line_reg <= line_next; col_reg <= col_next;
            tpos_reg <= tpos_next; tline_reg <= tline_next; tcol_reg <= tcol_next;
            tlen_reg <= tlen_next; kw_reg <= kw_next; plus_reg <= plus_next;
        end
    end

endmodule

`default_nettype wire

### rtl/stl_outq.sv
// ============================================================================
// Result queue
// Small FIFO of results that feeds the output channel.
// ============================================================================
`default_nettype none

module stl_outq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire stl_pkg::result_pair_t push_data,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output stl_pkg::result_t          out_data,
    output logic                      out_last
);
    import stl_pkg::*;

    // Four entries: two for results in flight and two so a new pair fits.
    result_t    mem_reg [4];
    logic       lastm_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [2:0] add;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rd_reg];
    assign out_last  = lastm_reg[rd_reg];
    assign add       = push ? (push_data.count2 ? 3'd2 : 3'd1) : 3'd0;
    // Room for a full pair, without counting on this cycle's pop.
    assign room      = (cnt_reg <= 3'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg]   <= push_data.first;
            lastm_reg[wr_reg] <= !push_data.count2;
            if (push_data.count2)
            begin
                mem_reg[wr_reg + 2'd1]   <= push_data.second;
                lastm_reg[wr_reg + 2'd1] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_reg + {1'b0, pop};
            wr_reg  <= wr_reg + add[1:0];
            cnt_reg <= cnt_reg + add - {2'b0, pop};
        end
    end

endmodule

`default_nettype wire

### rtl/sql_token_lexer_unit.sv
// ============================================================================
// SQL token lexer
// Turns a stream of SQL source bytes into tokens with position information.
// ============================================================================
// The lexer takes one source byte or one end item per clock. Each accepted
// transfer is registered and decoded by the lexer core once the result queue
// has room, and its zero, one or two results are written into that four-entry
// queue, which drives the output channel; a new item is accepted while the
// previous one is decoded, and results pass the input register and the queue.
// The input stalls only when the queue could not take a full pair of results.
// Results of one item leave in order, the final one marked by last. After an
// ERROR the lexer ignores bytes until the end item, which emits EOF and
// returns all position counters to their reset values.
`default_nettype none

module sql_token_lexer_unit #(
    parameter int STRING_CAPACITY = stl_pkg::STRING_CAPACITY_DEF,
    parameter int COUNTER_BITS    = stl_pkg::COUNTER_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       token_kind,
    output logic [15:0]      text_start,
    output logic [15:0]      text_length,
    output logic [15:0]      token_line,
    output logic [15:0]      start_column,
    output logic [7:0]       char_value,
    output logic             last
);
    import stl_pkg::*;

    logic         hold_reg;
    logic         cmd_reg;
    logic [7:0]   byte_reg;
    logic         room;
    logic         step;
    logic         any_result;
    result_pair_t pair;
    result_t      head;

    // The registered item is consumed whenever the queue can absorb a pair.
    assign step     = hold_reg && room;
    assign in_stall = hold_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (!in_stall)
            hold_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg  <= cmd;
            byte_reg <= byte_value;
        end
    end

    stl_core #(
        .STRING_CAPACITY (STRING_CAPACITY),
        .COUNTER_BITS    (COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (cmd_reg),
        .byte_value (byte_reg),
        .results    (pair),
        .any_result (any_result)
    );

    stl_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && any_result),
        .push_data (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head),
        .out_last  (last)
    );

    assign token_kind   = head.kind;
    assign text_start   = head.start;
    assign text_length  = head.length;
    assign token_line   = head.line;
    assign start_column = head.column;
    assign char_value   = head.char_value;

endmodule

`default_nettype wire
